/* hw/rtl/pdh_pkg.sv */
`timescale 1ns / 1ps
package pdh_pkg;

  localparam int DEF_MAX_REF_ATOMS    = 2048;
  localparam int DEF_MAX_TARGET_ATOMS = 256;
  localparam int DEF_NUM_BINS         = 256;
  localparam int DEF_COUNT_WIDTH      = 40;

  localparam int NUM_CLASSES = 6;
  localparam int POS_W       = 32;
  localparam int VALUE_W     = 40;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_FRAME  = 3'd1;
  localparam logic [2:0] KIND_RDBIN  = 3'd2;
  localparam logic [2:0] KIND_RDTOT  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DROP  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [2:0] CLS_OW   = 3'd0;
  localparam logic [2:0] CLS_HW   = 3'd1;
  localparam logic [2:0] CLS_C    = 3'd2;
  localparam logic [2:0] CLS_OC   = 3'd3;
  localparam logic [2:0] CLS_OB   = 3'd4;
  localparam logic [2:0] CLS_HC   = 3'd5;
  localparam logic [2:0] CLS_NONE = 3'd6;

  localparam logic [1:0] REG_BOX     = 2'd0;
  localparam logic [1:0] REG_INV_BOX = 2'd1;
  localparam logic [1:0] REG_INV_BW  = 2'd2;
  localparam logic [1:0] REG_BINS    = 2'd3;

  localparam logic [30:0] RST_BOX     = 31'd1597728;
  localparam logic [31:0] RST_INV_BOX = 32'd176171985;
  localparam logic [31:0] RST_INV_BW  = 32'd1310720;
  localparam logic [8:0]  RST_BINS    = 9'd240;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDB_A, ST_RDB_D, ST_EF_TOT, ST_EF_FETCH,
    ST_EF_START, ST_EF_WAIT, ST_EF_HRD, ST_EF_HWR
  } pdh_state_t;

  typedef enum logic [3:0] {
    D_IDLE, D_SUB, D_MQ, D_MQL, D_MSQ, D_ACC, D_SQRT, D_MBIN, D_OUT
  } dist_state_t;

  typedef struct packed {
    logic [30:0] box;
    logic [31:0] inv_box;
    logic [31:0] inv_bw;
  } pdh_cfg_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bin;
  } pdh_dist_res_t;

  function automatic logic [2:0] map_type(input logic [5:0] t);
    logic [2:0] c;
    case (t)
      6'd1: c = CLS_OW;
      6'd2: c = CLS_HW;
      6'd5, 6'd9: c = CLS_C;
      6'd7, 6'd11: c = CLS_OC;
      6'd6, 6'd10: c = CLS_OB;
      6'd8, 6'd12: c = CLS_HC;
      default: c = CLS_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] target_slot(input logic [2:0] c);
    logic [1:0] s;
    case (c)
      CLS_OC: s = 2'd0;
      CLS_OB: s = 2'd1;
      CLS_HC: s = 2'd2;
      default: s = 2'd3;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/pair_distance_histogram_pbc.sv */
`timescale 1ns / 1ps
// Pair-distance histogram under periodic boundaries.
// Items arrive on the in_ channel (valid and stall); every accepted item gives exactly
// one transfer on the out_ channel with a bin count or class total and a status code.
// Configuration registers are written and read over the APB port at byte addresses
// 0, 4, 8 and 12; write them only while the block is idle.
// An atom load, a class total read, an out-of-range bin read or an unused kind gives its
// result in the cycle after the transfer; an in-range bin read goes through ST_RDB_A
// and ST_RDB_D. End of frame adds the class counts to the totals, then runs each
// reference-target pair through the shared 32 by 32 multiplier, which serves three
// axes in turn, and the square-root unit, which resolves one root bit per cycle; a pair
// counted in a bin then reads and updates its histogram entry.
// A clear command sweeps all 8*NUM_BINS histogram entries, one entry per cycle, before
// its result appears. After reset the same sweep runs while in_stall stays high.
// Only one item is in work at a time. A result held by out_stall keeps the next
// item waiting until the held result has been taken.
module pair_distance_histogram_pbc #(
  parameter int MAX_REF_ATOMS    = pdh_pkg::DEF_MAX_REF_ATOMS,
  parameter int MAX_TARGET_ATOMS = pdh_pkg::DEF_MAX_TARGET_ATOMS,
  parameter int NUM_BINS         = pdh_pkg::DEF_NUM_BINS,
  parameter int COUNT_WIDTH      = pdh_pkg::DEF_COUNT_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [5:0]         in_atom_type,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [2:0]         in_pair_select,
  input  logic [7:0]         in_bin_index,
  input  logic [2:0]         in_class_select,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [39:0]        out_read_value,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pdh_pkg::*;

  localparam int RA_W   = $clog2(MAX_REF_ATOMS);
  localparam int TA_W   = $clog2(MAX_TARGET_ATOMS);
  localparam int HDEPTH = 8 * NUM_BINS;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int CW     = $clog2((MAX_REF_ATOMS > MAX_TARGET_ATOMS ?
                                  MAX_REF_ATOMS : MAX_TARGET_ATOMS) + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  pdh_state_t st_r, st_nxt;
  logic [30:0] box_r;
  logic [31:0] inv_box_r, inv_bw_r;
  logic [8:0]  bins_r;
  pdh_cfg_t    cfg;

  logic [CW-1:0]          cnt_r [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] tot_r [NUM_CLASSES];
  logic [CW:0]            nref;
  logic [CW+1:0]          ntgt;

  logic [RA_W-1:0] i_r;
  logic [TA_W-1:0] j_r;
  logic [HA_W-1:0] haddr_r, clr_r;
  logic            clr_reply_r;

  logic            out_valid_r;
  logic [39:0]     out_value_r;
  logic [1:0]      out_status_r;

  logic            accept, is_load, is_frame, is_rdbin, is_clear, bin_ok;
  logic [2:0]      cls;
  logic            cls_ok, is_ref, ref_we, tgt_we, drop;
  logic [96:0]     ref_q;
  logic [97:0]     tgt_q;
  logic [COUNT_WIDTH-1:0] hist_q, hist_wdata;
  logic [HA_W-1:0] hist_waddr;
  logic            hist_we, dist_start;
  pdh_dist_res_t   dres;
  logic            hit, last_pair, empty, frame_end, clr_last, out_set;
  logic [39:0]     out_value_nxt;
  logic [1:0]      out_status_nxt;

  assign cfg.box     = box_r;
  assign cfg.inv_box = inv_box_r;
  assign cfg.inv_bw  = inv_bw_r;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_BOX:     prdata = {1'b0, box_r};
      REG_INV_BOX: prdata = inv_box_r;
      REG_INV_BW:  prdata = inv_bw_r;
      REG_BINS:    prdata = {23'd0, bins_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r     <= RST_BOX;
      inv_box_r <= RST_INV_BOX;
      inv_bw_r  <= RST_INV_BW;
      bins_r    <= RST_BINS;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BOX:     box_r     <= pwdata[30:0];
        REG_INV_BOX: inv_box_r <= pwdata;
        REG_INV_BW:  inv_bw_r  <= pwdata;
        REG_BINS:    bins_r    <= pwdata[8:0];
        default:     ;
      endcase
    end
  end

  assign nref = (CW+1)'(cnt_r[CLS_OW]) + (CW+1)'(cnt_r[CLS_HW]);
  assign ntgt = (CW+2)'(cnt_r[CLS_C]) + (CW+2)'(cnt_r[CLS_OC])
              + (CW+2)'(cnt_r[CLS_OB]) + (CW+2)'(cnt_r[CLS_HC]);

  assign in_stall = !((st_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign is_load  = accept && in_kind == KIND_LOAD;
  assign is_frame = accept && in_kind == KIND_FRAME;
  assign is_rdbin = accept && in_kind == KIND_RDBIN;
  assign is_clear = accept && in_kind == KIND_CLEAR;
  assign bin_ok   = int'(in_bin_index) < NUM_BINS;

  assign cls    = map_type(in_atom_type);
  assign cls_ok = cls != CLS_NONE;
  assign is_ref = cls == CLS_OW || cls == CLS_HW;
  assign ref_we = is_load && cls_ok && is_ref && int'(nref) < MAX_REF_ATOMS;
  assign tgt_we = is_load && cls_ok && !is_ref && int'(ntgt) < MAX_TARGET_ATOMS;
  assign drop   = is_load && cls_ok && !ref_we && !tgt_we;

  pdh_ram #(.WIDTH(97), .DEPTH(MAX_REF_ATOMS)) u_ref_ram (
    .clk     (clk),
    .wr_en   (ref_we),
    .wr_addr (nref[RA_W-1:0]),
    .wr_data ({cls == CLS_HW, in_pos_x, in_pos_y, in_pos_z}),
    .rd_addr (i_r),
    .rd_data (ref_q)
  );

  pdh_ram #(.WIDTH(98), .DEPTH(MAX_TARGET_ATOMS)) u_tgt_ram (
    .clk     (clk),
    .wr_en   (tgt_we),
    .wr_addr (ntgt[TA_W-1:0]),
    .wr_data ({target_slot(cls), in_pos_x, in_pos_y, in_pos_z}),
    .rd_addr (j_r),
    .rd_data (tgt_q)
  );

  pdh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HDEPTH)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_addr (haddr_r),
    .rd_data (hist_q)
  );

  pdh_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .ref_pos (ref_q[95:0]),
    .tgt_pos (tgt_q[95:0]),
    .cfg     (cfg),
    .res     (dres)
  );

  assign hit = dres.bin < 32'((int'(bins_r) > NUM_BINS) ? NUM_BINS : int'(bins_r));
  assign last_pair = (int'(j_r) + 1 >= int'(ntgt)) && (int'(i_r) + 1 >= int'(nref));
  assign empty     = nref == '0 || ntgt == '0;
  assign clr_last  = clr_r == HA_W'(HDEPTH - 1);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_last) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (is_frame) st_nxt = ST_EF_TOT;
        else if (is_rdbin && bin_ok) st_nxt = ST_RDB_A;
        else if (is_clear) st_nxt = ST_CLEAR;
      end
      ST_RDB_A:    st_nxt = ST_RDB_D;
      ST_RDB_D:    st_nxt = ST_IDLE;
      ST_EF_TOT:   st_nxt = empty ? ST_IDLE : ST_EF_FETCH;
      ST_EF_FETCH: st_nxt = ST_EF_START;
      ST_EF_START: st_nxt = ST_EF_WAIT;
      ST_EF_WAIT: begin
        if (dres.done) begin
          if (hit) st_nxt = ST_EF_HRD;
          else st_nxt = last_pair ? ST_IDLE : ST_EF_FETCH;
        end
      end
      ST_EF_HRD:   st_nxt = ST_EF_HWR;
      ST_EF_HWR:   st_nxt = last_pair ? ST_IDLE : ST_EF_FETCH;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dist_start = st_r == ST_EF_START;
    hist_we    = st_r == ST_CLEAR || st_r == ST_EF_HWR;
    hist_waddr = (st_r == ST_CLEAR) ? clr_r : haddr_r;
    hist_wdata = (st_r == ST_CLEAR || hist_q == CNT_MAX) ? ((st_r == ST_CLEAR) ? '0 : CNT_MAX)
                                                         : hist_q + 1'b1;
    frame_end  = (st_r == ST_EF_TOT && empty)
              || (st_r == ST_EF_WAIT && dres.done && !hit && last_pair)
              || (st_r == ST_EF_HWR && last_pair);
    out_set        = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STATUS_OK;
    if (accept && !is_frame && !is_clear && !(is_rdbin && bin_ok)) begin
      out_set = 1'b1;
      if (drop) out_status_nxt = STATUS_DROP;
      if (is_rdbin) out_status_nxt = STATUS_RANGE;
      if (accept && in_kind == KIND_RDTOT) begin
        if (in_class_select < 3'(NUM_CLASSES)) out_value_nxt = 40'(tot_r[in_class_select]);
        else out_status_nxt = STATUS_RANGE;
      end
    end else if (st_r == ST_RDB_D) begin
      out_set       = 1'b1;
      out_value_nxt = 40'(hist_q);
    end else if (frame_end || (st_r == ST_CLEAR && clr_last && clr_reply_r)) begin
      out_set = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c] <= '0;
        tot_r[c] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_set) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (st_r == ST_CLEAR) clr_r <= clr_last ? '0 : clr_r + 1'b1;
      if (is_clear) begin
        clr_reply_r <= 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) tot_r[c] <= '0;
      end else if (st_r == ST_CLEAR && clr_last) begin
        clr_reply_r <= 1'b0;
      end
      if (ref_we || tgt_we) cnt_r[cls] <= cnt_r[cls] + 1'b1;
      if (st_r == ST_EF_TOT) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if ((COUNT_WIDTH+1)'(tot_r[c]) + (COUNT_WIDTH+1)'(cnt_r[c])
              > (COUNT_WIDTH+1)'(CNT_MAX)) tot_r[c] <= CNT_MAX;
          else tot_r[c] <= tot_r[c] + COUNT_WIDTH'(cnt_r[c]);
        end
      end
      if (frame_end) begin
        for (int c = 0; c < NUM_CLASSES; c++) cnt_r[c] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
    if (is_rdbin) begin
      haddr_r <= HA_W'(in_pair_select) * HA_W'(NUM_BINS) + HA_W'(in_bin_index);
    end
    if (st_r == ST_EF_WAIT && dres.done) begin
      haddr_r <= HA_W'({ref_q[96], tgt_q[97:96]}) * HA_W'(NUM_BINS) + HA_W'(dres.bin);
    end
    if (st_r == ST_EF_TOT) begin
      i_r <= '0;
      j_r <= '0;
    end else if ((st_r == ST_EF_WAIT && dres.done && !hit) || st_r == ST_EF_HWR) begin
      if (int'(j_r) + 1 >= int'(ntgt)) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  a_dist_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> st_r == ST_EF_WAIT)
    else $error("distance result outside of the pair loop");

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EF_START |-> (int'(i_r) < int'(nref)) && (int'(j_r) < int'(ntgt)))
    else $error("pair index beyond loaded atoms");

  a_hist_addr: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> int'(hist_waddr) < HDEPTH)
    else $error("histogram write beyond memory");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_set |-> !out_valid_r || !out_stall)
    else $error("result overwrites a pending transfer");

endmodule

/* hw/rtl/pdh_ram.sv */
`timescale 1ns / 1ps
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/pdh_isqrt.sv */
`timescale 1ns / 1ps
module pdh_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r, res_r, bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;
  logic        take;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign take  = {1'b0, v_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        v_r   <= v_r - trial[63:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

/* hw/rtl/pdh_dist.sv */
`timescale 1ns / 1ps
module pdh_dist (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [95:0]           ref_pos,
  input  logic [95:0]           tgt_pos,
  input  pdh_pkg::pdh_cfg_t     cfg,
  output pdh_pkg::pdh_dist_res_t res
);
  import pdh_pkg::*;

  dist_state_t        st_r, st_nxt;
  logic [1:0]         axis_r;
  logic [95:0]        a_r, b_r;
  logic signed [32:0] d_r;
  logic [63:0]        mul_r, mul_nxt, sum_r, sum_sat;
  logic [31:0]        mul_a, mul_b, mag, wm, ra, rb, root;
  logic [16:0]        qmag;
  logic signed [49:0] w, wabs;
  logic [64:0]        sum_full;
  logic               sq_start, sq_done;

  assign ra   = a_r[32*axis_r +: 32];
  assign rb   = b_r[32*axis_r +: 32];
  assign mag  = d_r[32] ? 32'(-d_r) : 32'(d_r);
  assign qmag = 17'(mul_r[63:48]) + 17'(mul_r[47]);
  assign w    = d_r[32] ? 50'(d_r) + signed'({2'b00, mul_r[47:0]})
                        : 50'(d_r) - signed'({2'b00, mul_r[47:0]});
  assign wabs = w[49] ? -w : w;
  assign wm   = (|wabs[49:32]) ? 32'hFFFF_FFFF : wabs[31:0];
  assign sum_full = {1'b0, sum_r} + {1'b0, mul_r};
  assign sum_sat  = sum_full[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_full[63:0];

  always_comb begin
    case (st_r)
      D_MQ: begin
        mul_a = mag;
        mul_b = cfg.inv_box;
      end
      D_MQL: begin
        mul_a = {15'd0, qmag};
        mul_b = {1'b0, cfg.box};
      end
      D_MSQ: begin
        mul_a = wm;
        mul_b = wm;
      end
      D_MBIN: begin
        mul_a = root;
        mul_b = cfg.inv_bw;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE: if (start) st_nxt = D_SUB;
      D_SUB:  st_nxt = D_MQ;
      D_MQ:   st_nxt = D_MQL;
      D_MQL:  st_nxt = D_MSQ;
      D_MSQ:  st_nxt = D_ACC;
      D_ACC:  st_nxt = (axis_r == 2'd2) ? D_SQRT : D_SUB;
      D_SQRT: if (sq_done) st_nxt = D_MBIN;
      D_MBIN: st_nxt = D_OUT;
      D_OUT:  st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_comb begin
    sq_start = (st_r == D_ACC) && (axis_r == 2'd2);
    res.done = (st_r == D_OUT);
    res.bin  = mul_r[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    if (st_r == D_IDLE && start) begin
      a_r    <= ref_pos;
      b_r    <= tgt_pos;
      axis_r <= 2'd0;
      sum_r  <= '0;
    end
    if (st_r == D_SUB) begin
      d_r <= signed'({ra[31], ra}) - signed'({rb[31], rb});
    end
    if (st_r == D_ACC) begin
      sum_r  <= sum_sat;
      axis_r <= axis_r + 2'd1;
    end
  end

  pdh_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sum_sat),
    .done  (sq_done),
    .root  (root)
  );

endmodule

/* tb/pdh_checker.sv */
`timescale 1ns / 1ps
module pdh_checker
  import pdh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [5:0]         in_atom_type,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [2:0]         in_pair_select,
  input  logic [7:0]         in_bin_index,
  input  logic [2:0]         in_class_select,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [39:0]        out_read_value,
  input  logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  localparam int NREF  = DEF_MAX_REF_ATOMS;
  localparam int NTGT  = DEF_MAX_TARGET_ATOMS;
  localparam int NBINS = DEF_NUM_BINS;
  localparam logic [63:0] COUNT_MAX = (64'd1 << DEF_COUNT_WIDTH) - 1;

  typedef struct {
    logic [39:0] value;
    logic [1:0]  status;
  } reading_t;

  reading_t readings_due[$];

  logic [30:0] box_q;
  logic [31:0] inv_box_q;
  logic [31:0] inv_bw_q;
  logic [8:0]  bins_q;

  logic [2:0]  ref_cls [NREF];
  longint      ref_pos [NREF][3];
  logic [2:0]  tgt_cls [NTGT];
  longint      tgt_pos [NTGT][3];
  int          class_cnt [NUM_CLASSES];
  logic [63:0] class_tot [NUM_CLASSES];
  logic [63:0] hist [8*NBINS];

  assign pending = readings_due.size();

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] top);
    if (a >= top || b > top - a) return top;
    return a + b;
  endfunction

  function automatic logic [2:0] class_of(logic [5:0] t);
    case (t)
      6'd1: return CLS_OW;
      6'd2: return CLS_HW;
      6'd5, 6'd9: return CLS_C;
      6'd7, 6'd11: return CLS_OC;
      6'd6, 6'd10: return CLS_OB;
      6'd8, 6'd12: return CLS_HC;
      default: return CLS_NONE;
    endcase
  endfunction

  function automatic int slot_of(logic [2:0] c);
    case (c)
      CLS_OC: return 0;
      CLS_OB: return 1;
      CLS_HC: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [63:0] wrapped_square(longint a, longint b);
    longint d, w;
    logic neg;
    logic [63:0] mag, prod, qmag, ql, wm;
    d = a - b;
    neg = d < 0;
    mag = neg ? -d : d;
    prod = mag * {32'd0, inv_box_q};
    qmag = (prod >> 48) + ((prod >> 47) & 64'd1);
    ql = qmag * {33'd0, box_q};
    w = neg ? d + longint'(ql) : d - longint'(ql);
    wm = w < 0 ? -w : w;
    if (wm > 64'hFFFF_FFFF) wm = 64'hFFFF_FFFF;
    return wm * wm;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic close_frame();
    int nref, ntgt, lim, h;
    logic [63:0] sum, r, bin;
    nref = class_cnt[0] + class_cnt[1];
    ntgt = class_cnt[2] + class_cnt[3] + class_cnt[4] + class_cnt[5];
    lim = bins_q > NBINS ? NBINS : bins_q;
    for (int c = 0; c < NUM_CLASSES; c++)
      class_tot[c] = sat_sum(class_tot[c], class_cnt[c], COUNT_MAX);
    for (int i = 0; i < nref && i < NREF; i++) begin
      for (int j = 0; j < ntgt && j < NTGT; j++) begin
        sum = 0;
        for (int k = 0; k < 3; k++)
          sum = sat_sum(sum, wrapped_square(ref_pos[i][k], tgt_pos[j][k]), '1);
        r = root_floor(sum);
        bin = (r * {32'd0, inv_bw_q}) >> 32;
        if (bin < lim) begin
          h = ((ref_cls[i] & 3'd1) * 4 + slot_of(tgt_cls[j])) * NBINS + int'(bin);
          hist[h] = sat_sum(hist[h], 1, COUNT_MAX);
        end
      end
    end
    foreach (class_cnt[c]) class_cnt[c] = 0;
  endtask

  task automatic predict_reading();
    reading_t e;
    logic [2:0] c;
    int nref, ntgt;
    e.value = 0;
    e.status = STATUS_OK;
    case (in_kind)
      KIND_LOAD: begin
        c = class_of(in_atom_type);
        nref = class_cnt[0] + class_cnt[1];
        ntgt = class_cnt[2] + class_cnt[3] + class_cnt[4] + class_cnt[5];
        if (c == CLS_OW || c == CLS_HW) begin
          if (nref < NREF) begin
            ref_cls[nref] = c;
            ref_pos[nref] = '{longint'(in_pos_x), longint'(in_pos_y), longint'(in_pos_z)};
            class_cnt[c]++;
          end else begin
            e.status = STATUS_DROP;
          end
        end else if (c != CLS_NONE) begin
          if (ntgt < NTGT) begin
            tgt_cls[ntgt] = c;
            tgt_pos[ntgt] = '{longint'(in_pos_x), longint'(in_pos_y), longint'(in_pos_z)};
            class_cnt[c]++;
          end else begin
            e.status = STATUS_DROP;
          end
        end
      end
      KIND_FRAME: close_frame();
      KIND_RDBIN: e.value = hist[in_pair_select * NBINS + in_bin_index];
      KIND_RDTOT: begin
        if (in_class_select < NUM_CLASSES) e.value = class_tot[in_class_select];
        else e.status = STATUS_RANGE;
      end
      KIND_CLEAR: begin
        foreach (hist[i]) hist[i] = 0;
        foreach (class_tot[c]) class_tot[c] = 0;
      end
      default: ;
    endcase
    readings_due.insert(readings_due.size(), e);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      box_q = RST_BOX;
      inv_box_q = RST_INV_BOX;
      inv_bw_q = RST_INV_BW;
      bins_q = RST_BINS;
      foreach (class_cnt[c]) class_cnt[c] = 0;
      foreach (class_tot[c]) class_tot[c] = 0;
      foreach (hist[i]) hist[i] = 0;
      readings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BOX: box_q = pwdata[30:0];
          REG_INV_BOX: inv_box_q = pwdata;
          REG_INV_BW: inv_bw_q = pwdata;
          REG_BINS: bins_q = pwdata[8:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          e = readings_due.pop_front();
          if (out_read_value !== e.value)
            report_mismatch($sformatf("read_value %0h, expected %0h", out_read_value, e.value));
          if (out_status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
        end
      end
      if (in_valid && !in_stall) predict_reading();
    end
  end

  initial errors = 0;

endmodule

/* tb/pair_distance_histogram_pbc_tb.sv */
`timescale 1ns / 1ps
module pair_distance_histogram_pbc_tb;
  import pdh_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic [5:0]         in_atom_type;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic [2:0]         in_pair_select;
  logic [7:0]         in_bin_index;
  logic [2:0]         in_class_select;
  logic               out_valid;
  logic               out_stall;
  logic [39:0]        out_read_value;
  logic [1:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int pending;
  int tx_idle;
  int rx_idle;
  int hold_left;
  int quiet_cycles;
  int items_sent;
  int coord_span;
  logic full_coords;

  int mapped_types [10] = '{1, 2, 5, 9, 7, 11, 6, 10, 8, 12};

  pair_distance_histogram_pbc dut (.*);

  pdh_checker chk (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(logic [2:0] kind, logic [5:0] atype = 0, logic [31:0] x = 0,
                      logic [31:0] y = 0, logic [31:0] z = 0, logic [2:0] psel_h = 0,
                      logic [7:0] bin = 0, logic [2:0] cls = 0);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_atom_type <= atype;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_pair_select <= psel_h;
    in_bin_index <= bin;
    in_class_select <= cls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(logic [31:0] box, logic [31:0] inv_box, logic [31:0] inv_bw,
                              logic [31:0] bin_count);
    go_quiet();
    write_reg(REG_BOX, box);
    write_reg(REG_INV_BOX, inv_box);
    write_reg(REG_INV_BW, inv_bw);
    write_reg(REG_BINS, bin_count);
  endtask

  function automatic logic [31:0] coord();
    if (full_coords || $urandom_range(19) == 0) return $urandom;
    return $urandom_range(2 * coord_span) - coord_span;
  endfunction

  task automatic load_atom(int atype);
    send(KIND_LOAD, atype, coord(), coord(), coord());
  endtask

  task automatic random_item();
    send($urandom_range(7), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom);
  endtask

  task automatic random_frames(int count);
    int target_count;
    target_count = items_sent + count;
    while (items_sent < target_count) begin
      repeat ($urandom_range(5)) load_atom(mapped_types[$urandom_range(1)]);
      repeat ($urandom_range(6)) load_atom(mapped_types[$urandom_range(9, 2)]);
      if ($urandom_range(3) == 0) load_atom($urandom_range(63));
      if ($urandom_range(4) == 0) random_item();
      send(KIND_FRAME);
      repeat ($urandom_range(5, 1)) begin
        if ($urandom_range(1)) send(KIND_RDBIN, 0, 0, 0, 0, $urandom, $urandom_range(63));
        else send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, $urandom_range(7));
      end
      if ($urandom_range(40) == 0) send(KIND_CLEAR);
      if ($urandom_range(10) == 0) send($urandom_range(7, 5));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_atom_type = 0;
    in_pos_x = 0;
    in_pos_y = 0;
    in_pos_z = 0;
    in_pair_select = 0;
    in_bin_index = 0;
    in_class_select = 0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 0;
    pwdata = 0;
    tx_idle = 27;
    rx_idle = 71;
    hold_left = 0;
    items_sent = 0;
    coord_span = 1597728;
    full_coords = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    set_geometry(RST_BOX, RST_INV_BOX, RST_INV_BW, RST_BINS);

    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 0);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 7);
    send(KIND_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send(KIND_LOAD, 2, 32'h0001_0000, 32'hFFFF_0000, 32'h0008_0000);
    foreach (mapped_types[i])
      if (i >= 2) send(KIND_LOAD, mapped_types[i], 32'h8000_0000 + i, 32'h7FFF_FFFF, i << 16);
    send(KIND_LOAD, 0, 1, 2, 3);
    send(KIND_LOAD, 63, 4, 5, 6);
    send(KIND_FRAME);
    send(KIND_FRAME);
    send(KIND_RDBIN, 0, 0, 0, 0, 0, 0);
    send(KIND_RDBIN, 0, 0, 0, 0, 7, 255);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 5);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 6);
    send(5);
    send(7);
    send(KIND_CLEAR);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 2);

    // Fill the target store past capacity while the receiver holds off.
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    repeat (DEF_MAX_TARGET_ATOMS + 2) load_atom(mapped_types[$urandom_range(9, 2)]);
    send(KIND_FRAME);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 0);
    send(KIND_RDTOT, 0, 0, 0, 0, 0, 0, 4);

    random_frames(120);

    tx_idle = 71;
    rx_idle = 27;
    coord_span = 4 << 16;
    set_geometry(4 << 16, 1 << 30, 1 << 20, 256);
    random_frames(100);

    tx_idle = 0;
    rx_idle = 0;
    full_coords = 1'b1;
    set_geometry(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 511);
    random_frames(40);
    full_coords = 1'b0;
    set_geometry(0, 0, RST_INV_BW, 0);
    random_frames(30);
    set_geometry(RST_BOX, RST_INV_BOX, 32'h0100_0000, 1);
    coord_span = 1597728;
    random_frames(40);
    repeat (30) random_item();

    go_quiet();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_ram.sv
hw/rtl/pdh_isqrt.sv
hw/rtl/pdh_dist.sv
hw/rtl/pair_distance_histogram_pbc.sv
tb/pdh_checker.sv
tb/pair_distance_histogram_pbc_tb.sv
